FILE: hw/rtl/dpp_pkg.sv
// dpp_pkg: word types, register codes and fixed-point helpers for depth_pixel_to_point
// used by dpp_front, dpp_back and depth_pixel_to_point; depends on nothing
`default_nettype none

package dpp_pkg;

    // configuration register codes
    localparam logic [1:0] REG_IMAGE_WIDTH      = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT     = 2'd1;
    localparam logic [1:0] REG_INVERSE_FOCAL    = 2'd2;
    localparam logic [1:0] REG_BIG_ENDIAN_COLOR = 2'd3;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    // magnitude of (size +- 1 - 2*counter), enough for sizes up to 16384
    localparam int unsigned SPAN_W    = 15;
    // span * inverse_focal
    localparam int unsigned M1_W      = SPAN_W + 32;
    localparam int unsigned SPLIT     = 24;
    localparam int unsigned LO_P_W    = SPLIT + 32;
    localparam int unsigned HI_P_W    = (M1_W - SPLIT) + 32;
    // span * inverse_focal * depth, plus rounding
    localparam int unsigned SUM_W     = M1_W + 32;
    localparam int unsigned FRAC_CUT  = 25;
    localparam int unsigned R_W       = SUM_W - FRAC_CUT;

    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_CUT - 1);
    localparam logic [R_W-1:0]   POS_LIMIT  = R_W'(32'h7FFF_FFFF);
    localparam logic [R_W-1:0]   NEG_LIMIT  = R_W'(32'h8000_0000);
    localparam logic [31:0]      COORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0]      COORD_MIN  = 32'h8000_0000;

    // result queue, sized to cover the multiply pipeline at full rate
    localparam int unsigned OUT_DEPTH   = 8;
    localparam int unsigned OUT_LEVEL_W = $clog2(OUT_DEPTH) + 1;
    localparam int unsigned JOB_DEPTH   = 4;

    typedef struct packed {
        logic [31:0] depth;
        logic [7:0]  color_first;
        logic [7:0]  color_second;
        logic [7:0]  color_third;
    } pixel_t;

    typedef struct packed {
        logic [31:0]        point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [7:0]         out_color_first;
        logic [7:0]         out_color_second;
        logic [7:0]         out_color_third;
        logic               saturated;
        logic               frame_end;
    } point_t;

    typedef struct packed {
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [31:0] inverse_focal;
        logic        big_endian_color;
    } cfg_t;

    // classified pixel handed from the front to the back
    typedef struct packed {
        logic [31:0]       depth;
        logic              y_neg;
        logic [SPAN_W-1:0] y_mag;
        logic              z_neg;
        logic [SPAN_W-1:0] z_mag;
        logic [7:0]        color_first;
        logic [7:0]        color_second;
        logic [7:0]        color_third;
        logic              frame_end;
    } job_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } coord_t;

    // apply sign to a rounded magnitude and clip to signed Q16.16
    function automatic coord_t saturate_coord(input logic neg, input logic [R_W-1:0] mag);
        coord_t c;
        c.sat   = 1'b0;
        c.value = mag[31:0];
        if (!neg)
        begin
            if (mag > POS_LIMIT)
            begin
                c.sat   = 1'b1;
                c.value = COORD_MAX;
            end
        end
        else
        begin
            if (mag > NEG_LIMIT)
            begin
                c.sat   = 1'b1;
                c.value = COORD_MIN;
            end
            else
            begin
                c.value = 32'd0 - mag[31:0];
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dpp_fifo.sv
// dpp_fifo: small first-in first-out queue of flat words held in registers
// generic, no package use; DEPTH must be a power of two
`default_nettype none

module dpp_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       rd_en,
    output logic      [WIDTH-1:0]           rd_data,
    output logic                            empty,
    output logic                            full,
    output logic      [$clog2(DEPTH):0]     level
);

    localparam int unsigned ADDR_W = $clog2(DEPTH);

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [ADDR_W:0]   wr_ptr_reg;
    logic [ADDR_W:0]   rd_ptr_reg;
    logic [ADDR_W:0]   wr_ptr_next;
    logic [ADDR_W:0]   rd_ptr_next;

    assign level   = wr_ptr_reg - rd_ptr_reg;
    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign full    = (wr_ptr_reg[ADDR_W-1:0] == rd_ptr_reg[ADDR_W-1:0])
                     && (wr_ptr_reg[ADDR_W] != rd_ptr_reg[ADDR_W]);
    assign rd_data = mem_reg[rd_ptr_reg[ADDR_W-1:0]];

    assign wr_ptr_next = wr_ptr_reg + (ADDR_W+1)'(wr_en);
    assign rd_ptr_next = rd_ptr_reg + (ADDR_W+1)'(rd_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg[ADDR_W-1:0]] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dpp_front.sv
// dpp_front: raster counters and per-pixel classification into a job word
// depends on dpp_pkg (pixel_t, cfg_t, job_t)
`default_nettype none

module dpp_front #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire dpp_pkg::cfg_t  cfg,
    input  wire logic           accept,
    input  wire dpp_pkg::pixel_t pixel,
    output dpp_pkg::job_t       job
);

    import dpp_pkg::*;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
    localparam int unsigned WCL_W = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HCL_W = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned HALF_W = SPAN_W + 1;

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [WCL_W-1:0]  w_cl;
    logic [HCL_W-1:0]  h_cl;
    logic              row_end;
    logic              frame_end;
    logic [HALF_W-1:0] half_y;
    logic [HALF_W-1:0] half_z;
    logic [HALF_W-1:0] neg_y;
    logic [HALF_W-1:0] neg_z;

    // zero counts as one, oversize counts as the maximum
    always_comb
    begin
        if (cfg.image_width == '0)
            w_cl = WCL_W'(1);
        else if (32'(cfg.image_width) > 32'(MAX_WIDTH))
            w_cl = WCL_W'(MAX_WIDTH);
        else
            w_cl = WCL_W'(cfg.image_width);

        if (cfg.image_height == '0)
            h_cl = HCL_W'(1);
        else if (32'(cfg.image_height) > 32'(MAX_HEIGHT))
            h_cl = HCL_W'(MAX_HEIGHT);
        else
            h_cl = HCL_W'(cfg.image_height);
    end

    assign row_end   = 32'(col_reg) >= (32'(w_cl) - 32'd1);
    assign frame_end = row_end && (32'(row_reg) >= (32'(h_cl) - 32'd1));

    // doubled offsets from the optical center, signed
    assign half_y = HALF_W'(w_cl) - HALF_W'(1) - (HALF_W'(col_reg) << 1);
    assign half_z = HALF_W'(h_cl) + HALF_W'(1) - (HALF_W'(row_reg) << 1);
    assign neg_y  = HALF_W'(0) - half_y;
    assign neg_z  = HALF_W'(0) - half_z;

    always_comb
    begin
        job.depth        = pixel.depth;
        job.y_neg        = half_y[HALF_W-1];
        job.z_neg        = half_z[HALF_W-1];
        job.y_mag        = half_y[HALF_W-1] ? neg_y[SPAN_W-1:0] : half_y[SPAN_W-1:0];
        job.z_mag        = half_z[HALF_W-1] ? neg_z[SPAN_W-1:0] : half_z[SPAN_W-1:0];
        // a size of one has no angle
        if (w_cl == WCL_W'(1))
            job.y_mag = '0;
        if (h_cl == HCL_W'(1))
            job.z_mag = '0;
        job.color_first  = cfg.big_endian_color ? pixel.color_first : pixel.color_third;
        job.color_second = pixel.color_second;
        job.color_third  = cfg.big_endian_color ? pixel.color_third : pixel.color_first;
        job.frame_end    = frame_end;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dpp_back.sv
// dpp_back: three-stage multiply pipeline for the lateral and vertical lanes
// depends on dpp_pkg (job_t, point_t, saturate_coord); issues against result queue room
`default_nettype none

module dpp_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [31:0]                   inverse_focal,
    input  wire logic                          job_valid,
    input  wire dpp_pkg::job_t                 job,
    output logic                               job_take,
    input  wire logic [dpp_pkg::OUT_LEVEL_W-1:0] out_level,
    output logic                               result_valid,
    output dpp_pkg::point_t                    result
);

    import dpp_pkg::*;

    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic              s1_valid_next, s2_valid_next, s3_valid_next;
    logic [1:0]        in_flight;

    // side data riding along the pipeline
    logic [31:0]       s1_depth_reg, s2_depth_reg, s3_depth_reg;
    logic              s1_y_neg_reg, s2_y_neg_reg, s3_y_neg_reg;
    logic              s1_z_neg_reg, s2_z_neg_reg, s3_z_neg_reg;
    logic [23:0]       s1_color_reg, s2_color_reg, s3_color_reg;
    logic              s1_fend_reg, s2_fend_reg, s3_fend_reg;

    logic [M1_W-1:0]   s1_y_m1_reg, s1_z_m1_reg;
    logic [LO_P_W-1:0] s2_y_lo_reg, s2_z_lo_reg;
    logic [HI_P_W-1:0] s2_y_hi_reg, s2_z_hi_reg;
    logic [SUM_W-1:0]  y_sum, z_sum;
    logic [R_W-1:0]    s3_y_r_reg, s3_z_r_reg;
    coord_t            y_out, z_out;

    assign in_flight = 2'(s1_valid_reg) + 2'(s2_valid_reg) + 2'(s3_valid_reg);
    // never start more than the result queue can still hold
    assign job_take  = job_valid
                       && ((32'(out_level) + 32'(in_flight)) < 32'(OUT_DEPTH));

    assign s1_valid_next = job_take;
    assign s2_valid_next = s1_valid_reg;
    assign s3_valid_next = s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // stage 1: span times inverse focal
    always_ff @(posedge clk)
    begin
        s1_y_m1_reg  <= M1_W'(job.y_mag) * M1_W'(inverse_focal);
        s1_z_m1_reg  <= M1_W'(job.z_mag) * M1_W'(inverse_focal);
        s1_depth_reg <= job.depth;
        s1_y_neg_reg <= job.y_neg;
        s1_z_neg_reg <= job.z_neg;
        s1_color_reg <= {job.color_first, job.color_second, job.color_third};
        s1_fend_reg  <= job.frame_end;
    end

    // stage 2: partial products against depth
    always_ff @(posedge clk)
    begin
        s2_y_lo_reg  <= LO_P_W'(s1_y_m1_reg[SPLIT-1:0]) * LO_P_W'(s1_depth_reg);
        s2_y_hi_reg  <= HI_P_W'(s1_y_m1_reg[M1_W-1:SPLIT]) * HI_P_W'(s1_depth_reg);
        s2_z_lo_reg  <= LO_P_W'(s1_z_m1_reg[SPLIT-1:0]) * LO_P_W'(s1_depth_reg);
        s2_z_hi_reg  <= HI_P_W'(s1_z_m1_reg[M1_W-1:SPLIT]) * HI_P_W'(s1_depth_reg);
        s2_depth_reg <= s1_depth_reg;
        s2_y_neg_reg <= s1_y_neg_reg;
        s2_z_neg_reg <= s1_z_neg_reg;
        s2_color_reg <= s1_color_reg;
        s2_fend_reg  <= s1_fend_reg;
    end

    // stage 3: recombine, round half up on the magnitude, drop 25 fraction bits
    assign y_sum = (SUM_W'(s2_y_hi_reg) << SPLIT) + SUM_W'(s2_y_lo_reg) + ROUND_HALF;
    assign z_sum = (SUM_W'(s2_z_hi_reg) << SPLIT) + SUM_W'(s2_z_lo_reg) + ROUND_HALF;

    always_ff @(posedge clk)
    begin
        s3_y_r_reg   <= y_sum[SUM_W-1:FRAC_CUT];
        s3_z_r_reg   <= z_sum[SUM_W-1:FRAC_CUT];
        s3_depth_reg <= s2_depth_reg;
        s3_y_neg_reg <= s2_y_neg_reg;
        s3_z_neg_reg <= s2_z_neg_reg;
        s3_color_reg <= s2_color_reg;
        s3_fend_reg  <= s2_fend_reg;
    end

    assign y_out = saturate_coord(s3_y_neg_reg, s3_y_r_reg);
    assign z_out = saturate_coord(s3_z_neg_reg, s3_z_r_reg);

    assign result_valid = s3_valid_reg;

    always_comb
    begin
        result.point_x          = s3_depth_reg;
        result.point_y          = y_out.value;
        result.point_z          = z_out.value;
        result.out_color_first  = s3_color_reg[23:16];
        result.out_color_second = s3_color_reg[15:8];
        result.out_color_third  = s3_color_reg[7:0];
        result.saturated        = y_out.sat || z_out.sat;
        result.frame_end        = s3_fend_reg;
    end

`ifndef SYNTH
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> ##3 result_valid)
        else $error("issued word did not leave the pipeline after three cycles");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (32'(out_level) < 32'(OUT_DEPTH)))
        else $error("result word pushed into a full result queue");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.saturated) |->
            (result.point_y == COORD_MAX || result.point_y == COORD_MIN
             || result.point_z == COORD_MAX || result.point_z == COORD_MIN))
        else $error("saturated flag set without a clipped coordinate");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/depth_pixel_to_point.sv
// depth_pixel_to_point: raster depth pixels in, colored pinhole points out
// Usage:
//   input queue: drive pixel and raise push; a word is taken on an edge with
//   push high and full low. Pixels arrive in raster order; the block keeps
//   its own column and row counters and marks the last pixel of a frame.
//   result queue: while empty is low the oldest point sits on point; it is
//   taken on an edge with pop high. One point per pixel, in order.
//   configuration: cfg_we with cfg_index and cfg_data writes one register in
//   a cycle; write only while no pixel is in flight.
// Path: a taken pixel passes the job queue, three multiply stages and the
//   result queue before its point is visible.
// Throughput: one pixel per cycle, limited by the single issue slot of the
//   three-stage multiply pipeline; the pipeline starts a word only when the
//   eight-entry result queue has room for it and everything in flight.
// Reset: both queues empty, counters at row 0 column 0, registers at
//   640 x 480, inverse focal 52429, reversed color order.
// Stall: if pop stays low the result queue fills, issue stops, then the
//   four-entry job queue fills and full rises; nothing is dropped.
// Depends on dpp_pkg, dpp_fifo, dpp_front, dpp_back.
`default_nettype none

module depth_pixel_to_point #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire dpp_pkg::pixel_t                 pixel,
    output logic                                 empty,
    input  wire logic                            pop,
    output dpp_pkg::point_t                      point,
    input  wire logic                            cfg_we,
    input  wire logic [dpp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dpp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import dpp_pkg::*;

    localparam int unsigned JOB_W   = $bits(job_t);
    localparam int unsigned POINT_W = $bits(point_t);

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    logic                   accept;
    job_t                   job_in;
    logic [JOB_W-1:0]       job_flat;
    job_t                   job_out;
    logic                   job_empty;
    logic                   job_take;
    logic [$clog2(JOB_DEPTH):0] job_level;
    logic                   res_valid;
    point_t                 res_point;
    logic [POINT_W-1:0]     point_flat;
    logic                   out_full;
    logic [OUT_LEVEL_W-1:0] out_level;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:      cfg_next.image_width      = cfg_data[12:0];
                REG_IMAGE_HEIGHT:     cfg_next.image_height     = cfg_data[12:0];
                REG_INVERSE_FOCAL:    cfg_next.inverse_focal    = cfg_data;
                REG_BIG_ENDIAN_COLOR: cfg_next.big_endian_color = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width      <= 13'd640;
            cfg_reg.image_height     <= 13'd480;
            cfg_reg.inverse_focal    <= 32'd52429;
            cfg_reg.big_endian_color <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign accept = push && !full;

    dpp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .accept (accept),
        .pixel  (pixel),
        .job    (job_in)
    );

    dpp_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (job_in),
        .rd_en   (job_take),
        .rd_data (job_flat),
        .empty   (job_empty),
        .full    (full),
        .level   (job_level)
    );

    assign job_out = job_t'(job_flat);

    dpp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .inverse_focal (cfg_reg.inverse_focal),
        .job_valid     (!job_empty && (job_level != '0)),
        .job           (job_out),
        .job_take      (job_take),
        .out_level     (out_level),
        .result_valid  (res_valid),
        .result        (res_point)
    );

    dpp_fifo #(
        .WIDTH (POINT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res_point),
        .rd_en   (pop && !empty),
        .rd_data (point_flat),
        .empty   (empty),
        .full    (out_full),
        .level   (out_level)
    );

    assign point = point_t'(point_flat);

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !out_full)
        else $error("result word arrived at a full result queue");

    a_full_means_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (out_level != '0))
        else $error("job queue full while the result queue is empty");

    a_take_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> !job_empty)
        else $error("job taken from an empty job queue");
`endif

endmodule

`default_nettype wire
